>>> hdl/line_rasterizer_defines.svh
// ----------------------------------------------------------------------------
// line_rasterizer_defines.svh
// Assertion macros shared by the line rasterizer RTL.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("line rasterizer check failed");

// next-cycle implication, disabled during reset
`define LR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("line rasterizer check failed");

`endif

>>> hdl/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// Shared codes, fixed widths and types of the line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

   typedef enum logic {
      CMD_START   = 1'b0,
      CMD_ADVANCE = 1'b1
   } command_type;

   localparam int SCREEN_BITS    = 13;
   localparam int REG_BITS       = 11;
   localparam int CSR_INDEX_BITS = 1;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_X = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_Y = 1'b1;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> hdl/lr_queue.sv
// ----------------------------------------------------------------------------
// lr_queue
// Small register queue with push/pop handshake and full/empty status.
// ----------------------------------------------------------------------------
module lr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_push,
   input  logic [WIDTH-1:0]        wr_data,
   input  logic                    rd_pop,
   output logic [WIDTH-1:0]        rd_data,
   output lr_pkg::queue_status_type status
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = wr_push && !status.full;
   assign do_pop       = rd_pop && !status.empty;
   assign rd_data      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> hdl/lr_front.sv
// ----------------------------------------------------------------------------
// lr_front
// Command decode: takes input words, works out the endpoint deltas and
// their signs, and hands the decoded command to the command queue.
// ----------------------------------------------------------------------------
module lr_front #(
   parameter int COORD_BITS  = 12,
   parameter int COLOUR_BITS = 4
) (
   input  logic                    push,
   output logic                    full,
   input  logic                    req_command,
   input  logic [COORD_BITS-1:0]   req_start_x,
   input  logic [COORD_BITS-1:0]   req_start_y,
   input  logic [COORD_BITS-1:0]   req_end_x,
   input  logic [COORD_BITS-1:0]   req_end_y,
   input  logic [COLOUR_BITS-1:0]  req_pen_colour,
   input  lr_pkg::queue_status_type cmd_status,
   output logic                    cmd_push,
   output logic                    dec_is_start,
   output logic                    dec_neg_x,
   output logic                    dec_neg_y,
   output logic [COORD_BITS-1:0]   dec_abs_x,
   output logic [COORD_BITS-1:0]   dec_abs_y,
   output logic [COORD_BITS-1:0]   dec_x0,
   output logic [COORD_BITS-1:0]   dec_y0,
   output logic [COLOUR_BITS-1:0]  dec_colour
);

   logic [COORD_BITS:0] delta_x, delta_y;
   logic [COORD_BITS:0] mag_x, mag_y;

   assign full     = cmd_status.full;
   assign cmd_push = push && !cmd_status.full;

   assign delta_x = {req_end_x[COORD_BITS-1], req_end_x}
                  - {req_start_x[COORD_BITS-1], req_start_x};
   assign delta_y = {req_end_y[COORD_BITS-1], req_end_y}
                  - {req_start_y[COORD_BITS-1], req_start_y};

   assign mag_x = delta_x[COORD_BITS] ? (~delta_x + 1'b1) : delta_x;
   assign mag_y = delta_y[COORD_BITS] ? (~delta_y + 1'b1) : delta_y;

   // |delta| never exceeds 2^COORD_BITS - 1, so the top bit drops cleanly
   assign dec_is_start = (req_command == lr_pkg::CMD_START);
   assign dec_neg_x    = delta_x[COORD_BITS];
   assign dec_neg_y    = delta_y[COORD_BITS];
   assign dec_abs_x    = mag_x[COORD_BITS-1:0];
   assign dec_abs_y    = mag_y[COORD_BITS-1:0];
   assign dec_x0       = req_start_x;
   assign dec_y0       = req_start_y;
   assign dec_colour   = req_pen_colour;

endmodule

>>> hdl/lr_back.sv
// ----------------------------------------------------------------------------
// lr_back
// Line walker: sets up the Bresenham state on a start word, steps it on each
// advance in a line, pushing each screen-mapped pixel into the result queue.
// ----------------------------------------------------------------------------
`include "line_rasterizer_defines.svh"

module lr_back #(
   parameter int COORD_BITS  = 12,
   parameter int COLOUR_BITS = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [lr_pkg::REG_BITS-1:0]    origin_x,
   input  logic [lr_pkg::REG_BITS-1:0]    origin_y,
   input  lr_pkg::queue_status_type       cmd_status,
   output logic                           cmd_pop,
   input  logic                           dec_is_start,
   input  logic                           dec_neg_x,
   input  logic                           dec_neg_y,
   input  logic [COORD_BITS-1:0]          dec_abs_x,
   input  logic [COORD_BITS-1:0]          dec_abs_y,
   input  logic [COORD_BITS-1:0]          dec_x0,
   input  logic [COORD_BITS-1:0]          dec_y0,
   input  logic [COLOUR_BITS-1:0]         dec_colour,
   input  lr_pkg::queue_status_type       res_status,
   output logic                           res_push,
   output logic [lr_pkg::SCREEN_BITS-1:0] res_screen_x,
   output logic [lr_pkg::SCREEN_BITS-1:0] res_screen_y,
   output logic [COLOUR_BITS-1:0]         res_colour,
   output logic                           res_last
);

   localparam int ERR_BITS = COORD_BITS + 3;
   localparam int TWICE_BITS = COORD_BITS + 1;
   localparam int EXT_BITS =
      (COORD_BITS > lr_pkg::SCREEN_BITS) ? COORD_BITS : lr_pkg::SCREEN_BITS;

   logic [COORD_BITS-1:0]  cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]  cur_y_ff, cur_y_in;
   logic [ERR_BITS-1:0]    error_term_ff, error_term_in;
   logic [TWICE_BITS-1:0]  twice_minor_ff, twice_minor_in;
   logic [TWICE_BITS-1:0]  twice_major_ff, twice_major_in;
   logic                   step_x_negative_ff, step_x_negative_in;
   logic                   step_y_negative_ff, step_y_negative_in;
   logic                   x_is_major_ff, x_is_major_in;
   logic [COORD_BITS-1:0]  steps_left_ff, steps_left_in;
   logic                   drawing_ff, drawing_in;
   logic [COLOUR_BITS-1:0] held_colour_ff, held_colour_in;

   logic                   new_x_major;
   logic [COORD_BITS-1:0]  new_major, new_minor;
   logic                   step_minor, move_x, move_y;
   logic [EXT_BITS-1:0]    sum_x, diff_y;

   assign cmd_pop     = !cmd_status.empty && !res_status.full;
   assign new_x_major = (dec_abs_y < dec_abs_x);
   assign new_major   = new_x_major ? dec_abs_x : dec_abs_y;
   assign new_minor   = new_x_major ? dec_abs_y : dec_abs_x;
   assign step_minor  = !error_term_ff[ERR_BITS-1];
   assign move_x      = x_is_major_ff || step_minor;
   assign move_y      = !x_is_major_ff || step_minor;

   always_comb begin
      cur_x_in           = cur_x_ff;
      cur_y_in           = cur_y_ff;
      error_term_in      = error_term_ff;
      twice_minor_in     = twice_minor_ff;
      twice_major_in     = twice_major_ff;
      step_x_negative_in = step_x_negative_ff;
      step_y_negative_in = step_y_negative_ff;
      x_is_major_in      = x_is_major_ff;
      steps_left_in      = steps_left_ff;
      drawing_in         = drawing_ff;
      held_colour_in     = held_colour_ff;
      res_push           = 1'b0;
      if (cmd_pop) begin
         if (dec_is_start) begin
            // a start abandons any line in progress
            step_x_negative_in = dec_neg_x;
            step_y_negative_in = dec_neg_y;
            x_is_major_in      = new_x_major;
            twice_major_in     = {new_major, 1'b0};
            twice_minor_in     = {new_minor, 1'b0};
            error_term_in      = {2'b00, new_minor, 1'b0} - {3'b000, new_major};
            steps_left_in      = new_major;
            cur_x_in           = dec_x0;
            cur_y_in           = dec_y0;
            held_colour_in     = dec_colour;
            drawing_in         = (new_major != '0);
            res_push           = 1'b1;
         end else if (drawing_ff) begin
            if (move_x) begin
               cur_x_in = step_x_negative_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
            end
            if (move_y) begin
               cur_y_in = step_y_negative_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
            end
            if (step_minor) begin
               error_term_in = error_term_ff + {2'b00, twice_minor_ff}
                             - {2'b00, twice_major_ff};
            end else begin
               error_term_in = error_term_ff + {2'b00, twice_minor_ff};
            end
            steps_left_in = steps_left_ff - 1'b1;
            drawing_in    = (steps_left_in != '0);
            res_push      = 1'b1;
         end
      end
   end

   // screen mapping wraps modulo 2^SCREEN_BITS
   assign sum_x = EXT_BITS'($signed(cur_x_in)) + EXT_BITS'(origin_x);
   assign diff_y = EXT_BITS'(origin_y) - EXT_BITS'($signed(cur_y_in));
   assign res_screen_x = sum_x[lr_pkg::SCREEN_BITS-1:0];
   assign res_screen_y = diff_y[lr_pkg::SCREEN_BITS-1:0];
   assign res_colour   = held_colour_in;
   assign res_last     = (steps_left_in == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff           <= '0;
         cur_y_ff           <= '0;
         error_term_ff      <= '0;
         twice_minor_ff     <= '0;
         twice_major_ff     <= '0;
         step_x_negative_ff <= 1'b0;
         step_y_negative_ff <= 1'b0;
         x_is_major_ff      <= 1'b0;
         steps_left_ff      <= '0;
         drawing_ff         <= 1'b0;
         held_colour_ff     <= '0;
      end else begin
         cur_x_ff           <= cur_x_in;
         cur_y_ff           <= cur_y_in;
         error_term_ff      <= error_term_in;
         twice_minor_ff     <= twice_minor_in;
         twice_major_ff     <= twice_major_in;
         step_x_negative_ff <= step_x_negative_in;
         step_y_negative_ff <= step_y_negative_in;
         x_is_major_ff      <= x_is_major_in;
         steps_left_ff      <= steps_left_in;
         drawing_ff         <= drawing_in;
         held_colour_ff     <= held_colour_in;
      end
   end

   `LR_ASSERT_NOW(a_push_has_room, res_push, !res_status.full)
   `LR_ASSERT_NOW(a_drawing_matches_steps, 1'b1, drawing_ff == (steps_left_ff != '0))
   `LR_ASSERT_NOW(a_idle_advance_silent, cmd_pop && !dec_is_start && !drawing_ff, !res_push)
   `LR_ASSERT_NEXT(a_last_ends_line, res_push && res_last, !drawing_ff)

endmodule

>>> hdl/line_rasterizer.sv
// ----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line rasterizer with queue-style command and pixel ports.
// ----------------------------------------------------------------------------
// Takes one command word per cycle while full is low and delivers at most
// one pixel word per cycle; a start command yields its first pixel, each
// advance the next one, and an advance with no line in progress yields
// nothing. Decoded words wait in a two-word command queue; the line walker,
// which does one add/compare per axis per step, puts its pixels into a
// two-word result queue, which feeds the rsp ports. full rises only when
// pop is held off long enough for both queues to fill. There is no
// clearing pass after reset. origin_x and origin_y are applied as each
// pixel is produced, so write them only while no line is pending.
module line_rasterizer #(
   parameter int COORD_BITS  = 12,
   parameter int COLOUR_BITS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic                                req_command,
   input  logic [COORD_BITS-1:0]               req_start_x,
   input  logic [COORD_BITS-1:0]               req_start_y,
   input  logic [COORD_BITS-1:0]               req_end_x,
   input  logic [COORD_BITS-1:0]               req_end_y,
   input  logic [COLOUR_BITS-1:0]              req_pen_colour,
   output logic                                empty,
   input  logic                                pop,
   output logic [lr_pkg::SCREEN_BITS-1:0]      rsp_screen_x,
   output logic [lr_pkg::SCREEN_BITS-1:0]      rsp_screen_y,
   output logic [COLOUR_BITS-1:0]              rsp_pixel_colour,
   output logic                                rsp_last_pixel,
   input  logic                                csr_write_enable,
   input  logic [lr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lr_pkg::REG_BITS-1:0]         csr_write_data
);

   localparam int CMD_BITS = 3 + 4 * COORD_BITS + COLOUR_BITS;
   localparam int RES_BITS = 2 * lr_pkg::SCREEN_BITS + COLOUR_BITS + 1;

   logic [lr_pkg::REG_BITS-1:0] origin_x_ff, origin_y_ff;

   lr_pkg::queue_status_type cmd_status, res_status;
   logic                    cmd_push, cmd_pop, res_push;
   logic [CMD_BITS-1:0]     cmd_wdata, cmd_rdata;
   logic [RES_BITS-1:0]     res_wdata, res_rdata;

   logic                    fd_is_start, fd_neg_x, fd_neg_y;
   logic [COORD_BITS-1:0]   fd_abs_x, fd_abs_y, fd_x0, fd_y0;
   logic [COLOUR_BITS-1:0]  fd_colour;
   logic                    bk_is_start, bk_neg_x, bk_neg_y;
   logic [COORD_BITS-1:0]   bk_abs_x, bk_abs_y, bk_x0, bk_y0;
   logic [COLOUR_BITS-1:0]  bk_colour;

   logic [lr_pkg::SCREEN_BITS-1:0] res_screen_x, res_screen_y;
   logic [COLOUR_BITS-1:0]         res_colour;
   logic                           res_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            lr_pkg::CSR_ORIGIN_X: origin_x_ff <= csr_write_data;
            lr_pkg::CSR_ORIGIN_Y: origin_y_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   lr_front #(
      .COORD_BITS  (COORD_BITS),
      .COLOUR_BITS (COLOUR_BITS)
   ) u_front (
      .push           (push),
      .full           (full),
      .req_command    (req_command),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_pen_colour (req_pen_colour),
      .cmd_status     (cmd_status),
      .cmd_push       (cmd_push),
      .dec_is_start   (fd_is_start),
      .dec_neg_x      (fd_neg_x),
      .dec_neg_y      (fd_neg_y),
      .dec_abs_x      (fd_abs_x),
      .dec_abs_y      (fd_abs_y),
      .dec_x0         (fd_x0),
      .dec_y0         (fd_y0),
      .dec_colour     (fd_colour)
   );

   assign cmd_wdata = {fd_is_start, fd_neg_x, fd_neg_y, fd_abs_x, fd_abs_y,
                       fd_x0, fd_y0, fd_colour};

   lr_queue #(
      .WIDTH (CMD_BITS),
      .DEPTH (lr_pkg::QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_push (cmd_push),
      .wr_data (cmd_wdata),
      .rd_pop  (cmd_pop),
      .rd_data (cmd_rdata),
      .status  (cmd_status)
   );

   assign {bk_is_start, bk_neg_x, bk_neg_y, bk_abs_x, bk_abs_y,
           bk_x0, bk_y0, bk_colour} = cmd_rdata;

   lr_back #(
      .COORD_BITS  (COORD_BITS),
      .COLOUR_BITS (COLOUR_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .origin_x     (origin_x_ff),
      .origin_y     (origin_y_ff),
      .cmd_status   (cmd_status),
      .cmd_pop      (cmd_pop),
      .dec_is_start (bk_is_start),
      .dec_neg_x    (bk_neg_x),
      .dec_neg_y    (bk_neg_y),
      .dec_abs_x    (bk_abs_x),
      .dec_abs_y    (bk_abs_y),
      .dec_x0       (bk_x0),
      .dec_y0       (bk_y0),
      .dec_colour   (bk_colour),
      .res_status   (res_status),
      .res_push     (res_push),
      .res_screen_x (res_screen_x),
      .res_screen_y (res_screen_y),
      .res_colour   (res_colour),
      .res_last     (res_last)
   );

   assign res_wdata = {res_screen_x, res_screen_y, res_colour, res_last};

   lr_queue #(
      .WIDTH (RES_BITS),
      .DEPTH (lr_pkg::QUEUE_DEPTH)
   ) u_res_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_push (res_push),
      .wr_data (res_wdata),
      .rd_pop  (pop),
      .rd_data (res_rdata),
      .status  (res_status)
   );

   assign empty = res_status.empty;
   assign {rsp_screen_x, rsp_screen_y, rsp_pixel_colour, rsp_last_pixel} = res_rdata;

endmodule
